>>> rtl/dtls_record_rx_replay_filter_core_assert.svh
// ----------------------------------------------------------------------------
// DTLS record receive filter - assertion macros
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef DTLS_RECORD_RX_REPLAY_FILTER_CORE_ASSERT_SVH
`define DTLS_RECORD_RX_REPLAY_FILTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// expression must never hold outside reset
`define DRF_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("drf assertion failed: never condition");

// antecedent in one cycle forces consequent in the next
`define DRF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("drf assertion failed: next-cycle condition");

`else

`define DRF_ASSERT_NEVER(lbl, clk, rst, expr)
`define DRF_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> rtl/drf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drf_pkg
// Shared types and constants of the DTLS record receive replay filter.
// ----------------------------------------------------------------------------
package drf_pkg;

   // field widths
   localparam int COUNT_W = 16;
   localparam int TYPE_W  = 8;
   localparam int EPOCH_W = 16;
   localparam int SEQ_W   = 48;
   localparam int LEN_W   = 16;
   localparam int NUM_W   = EPOCH_W + SEQ_W;

   // record header layout
   localparam int HEADER_BYTES = 13;
   localparam logic [COUNT_W-1:0] POS_TYPE     = 16'd0;
   localparam logic [COUNT_W-1:0] POS_EPOCH_HI = 16'd3;
   localparam logic [COUNT_W-1:0] POS_EPOCH_LO = 16'd4;
   localparam logic [COUNT_W-1:0] POS_SEQ_FIRST = 16'd5;
   localparam logic [COUNT_W-1:0] POS_SEQ_LAST  = 16'd10;
   localparam logic [COUNT_W-1:0] POS_LEN_HI   = 16'd11;
   localparam logic [COUNT_W-1:0] POS_LEN_LO   = 16'd12;
   localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hFFFF;

   // defaults for top-level parameters
   localparam int WIN_SIZE_DEF    = 64;
   localparam int QUEUE_DEPTH_DEF = 4;

   // request kinds on the input channel and in the queue
   typedef enum logic {
      REQ_BYTE  = 1'b0,
      REQ_CLEAR = 1'b1
   } req_kind_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_ACCEPT      = 3'd0,
      ST_TOO_SHORT   = 3'd1,
      ST_LEN_EXCEEDS = 3'd2,
      ST_TOO_OLD     = 3'd3,
      ST_DUPLICATE   = 3'd4
   } status_type;

   // one queued command from front to back
   typedef struct packed {
      req_kind_type         kind;
      status_type           status;
      logic [TYPE_W-1:0]    rec_type;
      logic [EPOCH_W-1:0]   epoch;
      logic [SEQ_W-1:0]     seq;
      logic [LEN_W-1:0]     rec_len;
      logic [COUNT_W-1:0]   dgram_len;
   } qentry_type;

endpackage

>>> rtl/dtls_record_rx_replay_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtls_record_rx_replay_filter_core
// DTLS record header capture, length check and 64-entry anti-replay window.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one datagram byte per transaction (req_type = 0), with
//    req_last_byte on the final byte, or a window clear (req_type = 1).
//  - rsp_* carries one result per datagram: status, captured header fields
//    and the saturated datagram byte count. Clears give no result.
//  - csr_wr_en / csr_wr_data set replay_enable; write only while idle.
// Throughput: one byte per cycle sustained. The byte stage only waits when
// the command queue between header capture and window check is full.
// Result path: the edge that takes the last byte writes the queue; the window
// verdict is loaded into the result register once that command is at the queue
// head and the result register is free, and rsp_valid rises with it.
// The window check handles one command per cycle unless a datagram waits on a
// stalled result; its 64-bit compare and bitmap shift set the cycle.
// Reset: synchronous, clears byte count, header, window, queue and
// replay_enable. No clearing pass is needed.
// Stall: a stalled result holds; the queue keeps absorbing datagram ends and
// clears until full, then req_stall rises.
// ----------------------------------------------------------------------------
`include "dtls_record_rx_replay_filter_core_assert.svh"

module dtls_record_rx_replay_filter_core #(
   parameter int WIN_SIZE    = drf_pkg::WIN_SIZE_DEF,
   parameter int QUEUE_DEPTH = drf_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_last_byte,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_status,
   output logic [drf_pkg::TYPE_W-1:0]    rsp_record_type,
   output logic [drf_pkg::EPOCH_W-1:0]   rsp_epoch_out,
   output logic [drf_pkg::SEQ_W-1:0]     rsp_seq_out,
   output logic [drf_pkg::LEN_W-1:0]     rsp_record_length,
   output logic [drf_pkg::COUNT_W-1:0]   rsp_datagram_length
);

   logic                 q_push;
   drf_pkg::qentry_type  q_push_entry;
   logic                 q_full;
   logic                 q_not_empty;
   drf_pkg::qentry_type  q_head;
   logic                 q_pop;
   logic                 head_is_byte;

   assign req_stall    = q_full;
   assign head_is_byte = (q_head.kind == drf_pkg::REQ_BYTE);

   // byte intake and header capture
   drf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .queue_full (q_full),
      .req_type   (req_type),
      .data_byte  (req_data_byte),
      .last_byte  (req_last_byte),
      .push       (q_push),
      .push_entry (q_push_entry)
   );

   // command queue
   drf_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   // replay window and result register
   drf_back #(
      .WIN_SIZE (WIN_SIZE)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .head_valid          (q_not_empty),
      .head                (q_head),
      .pop                 (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_record_type     (rsp_record_type),
      .rsp_epoch_out       (rsp_epoch_out),
      .rsp_seq_out         (rsp_seq_out),
      .rsp_record_length   (rsp_record_length),
      .rsp_datagram_length (rsp_datagram_length)
   );

   // checks
   `DRF_ASSERT_NEVER(a_no_push_when_full, clock, reset, q_push && q_full)
   `DRF_ASSERT_NEVER(a_no_dgram_pop_into_stalled_rsp, clock, reset, q_pop && head_is_byte && rsp_valid && rsp_stall)
   `DRF_ASSERT_NEXT(a_no_result_from_empty_queue, clock, reset, !q_not_empty && !rsp_valid, !rsp_valid)

endmodule

>>> rtl/drf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drf_front
// Byte intake: counts datagram bytes, captures the record header and runs the
// length checks; pushes one command per datagram end or window clear.
// ----------------------------------------------------------------------------
module drf_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic                       queue_full,
   input  logic                       req_type,
   input  logic [7:0]                 data_byte,
   input  logic                       last_byte,
   output logic                       push,
   output drf_pkg::qentry_type        push_entry
);

   logic [drf_pkg::COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [drf_pkg::TYPE_W-1:0]  hdr_type_ff, hdr_type_in;
   logic [drf_pkg::EPOCH_W-1:0] hdr_epoch_ff, hdr_epoch_in;
   logic [drf_pkg::SEQ_W-1:0]   hdr_seq_ff, hdr_seq_in;
   logic [drf_pkg::LEN_W-1:0]   hdr_len_ff, hdr_len_in;

   logic [drf_pkg::COUNT_W-1:0] cnt_next;
   logic [drf_pkg::TYPE_W-1:0]  type_next;
   logic [drf_pkg::EPOCH_W-1:0] epoch_next;
   logic [drf_pkg::SEQ_W-1:0]   seq_next;
   logic [drf_pkg::LEN_W-1:0]   len_next;
   logic                        accept;
   logic                        is_clear;
   logic                        byte_acc;
   logic [drf_pkg::LEN_W:0]     need_len;
   drf_pkg::status_type         len_status;

   assign accept   = in_valid && !queue_full;
   assign is_clear = (req_type == drf_pkg::REQ_CLEAR);
   assign byte_acc = accept && !is_clear;

   // header capture at the current byte position
   always_comb begin
      type_next  = hdr_type_ff;
      epoch_next = hdr_epoch_ff;
      seq_next   = hdr_seq_ff;
      len_next   = hdr_len_ff;
      priority if (byte_count_ff == drf_pkg::POS_TYPE) begin
         type_next = data_byte;
      end else if (byte_count_ff == drf_pkg::POS_EPOCH_HI ||
                   byte_count_ff == drf_pkg::POS_EPOCH_LO) begin
         epoch_next = {hdr_epoch_ff[drf_pkg::EPOCH_W-9:0], data_byte};
      end else if (byte_count_ff >= drf_pkg::POS_SEQ_FIRST &&
                   byte_count_ff <= drf_pkg::POS_SEQ_LAST) begin
         seq_next = {hdr_seq_ff[drf_pkg::SEQ_W-9:0], data_byte};
      end else if (byte_count_ff == drf_pkg::POS_LEN_HI ||
                   byte_count_ff == drf_pkg::POS_LEN_LO) begin
         len_next = {hdr_len_ff[drf_pkg::LEN_W-9:0], data_byte};
      end else begin
         // version bytes and payload: nothing captured
      end
   end

   // saturating byte count
   assign cnt_next = (byte_count_ff == drf_pkg::COUNT_MAX) ? byte_count_ff
                                                           : byte_count_ff + 1'b1;

   // length checks on the datagram end
   assign need_len = {1'b0, len_next} + (drf_pkg::LEN_W+1)'(drf_pkg::HEADER_BYTES);

   always_comb begin
      priority if (cnt_next < drf_pkg::COUNT_W'(drf_pkg::HEADER_BYTES)) begin
         len_status = drf_pkg::ST_TOO_SHORT;
      end else if (need_len > {1'b0, cnt_next}) begin
         len_status = drf_pkg::ST_LEN_EXCEEDS;
      end else begin
         len_status = drf_pkg::ST_ACCEPT;
      end
   end

   // queue push
   assign push = accept && (is_clear || last_byte);

   always_comb begin
      push_entry.kind      = is_clear ? drf_pkg::REQ_CLEAR : drf_pkg::REQ_BYTE;
      push_entry.status    = len_status;
      push_entry.rec_type  = type_next;
      push_entry.epoch     = epoch_next;
      push_entry.seq       = seq_next;
      push_entry.rec_len   = len_next;
      push_entry.dgram_len = cnt_next;
   end

   // next header state
   always_comb begin
      byte_count_in = byte_count_ff;
      hdr_type_in   = hdr_type_ff;
      hdr_epoch_in  = hdr_epoch_ff;
      hdr_seq_in    = hdr_seq_ff;
      hdr_len_in    = hdr_len_ff;
      if (byte_acc) begin
         if (last_byte) begin
            byte_count_in = '0;
            hdr_type_in   = '0;
            hdr_epoch_in  = '0;
            hdr_seq_in    = '0;
            hdr_len_in    = '0;
         end else begin
            byte_count_in = cnt_next;
            hdr_type_in   = type_next;
            hdr_epoch_in  = epoch_next;
            hdr_seq_in    = seq_next;
            hdr_len_in    = len_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         hdr_type_ff   <= '0;
         hdr_epoch_ff  <= '0;
         hdr_seq_ff    <= '0;
         hdr_len_ff    <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
         hdr_type_ff   <= hdr_type_in;
         hdr_epoch_ff  <= hdr_epoch_in;
         hdr_seq_ff    <= hdr_seq_in;
         hdr_len_ff    <= hdr_len_in;
      end
   end

endmodule

>>> rtl/drf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drf_queue
// Small register queue of commands between intake and window logic.
// ----------------------------------------------------------------------------
module drf_queue #(
   parameter int QUEUE_DEPTH = drf_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  drf_pkg::qentry_type   push_entry,
   input  logic                  pop,
   output logic                  full,
   output logic                  not_empty,
   output drf_pkg::qentry_type   head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   drf_pkg::qentry_type slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_FULL);
   assign not_empty = (count_ff != '0);
   assign head      = slots_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> rtl/drf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drf_back
// Anti-replay window: tests and updates epoch:sequence against a sliding
// bitmap and drives the result register.
// ----------------------------------------------------------------------------
module drf_back #(
   parameter int WIN_SIZE = drf_pkg::WIN_SIZE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data,
   input  logic                          head_valid,
   input  drf_pkg::qentry_type           head,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_status,
   output logic [drf_pkg::TYPE_W-1:0]    rsp_record_type,
   output logic [drf_pkg::EPOCH_W-1:0]   rsp_epoch_out,
   output logic [drf_pkg::SEQ_W-1:0]     rsp_seq_out,
   output logic [drf_pkg::LEN_W-1:0]     rsp_record_length,
   output logic [drf_pkg::COUNT_W-1:0]   rsp_datagram_length
);

   localparam int SHW = $clog2(WIN_SIZE);
   localparam logic [drf_pkg::NUM_W-1:0] WIN_LIMIT = drf_pkg::NUM_W'(WIN_SIZE);
   localparam logic [WIN_SIZE-1:0]      BIT_ZERO  = WIN_SIZE'(1);

   logic                         replay_en_ff, replay_en_in;
   logic [drf_pkg::NUM_W-1:0]    highest_ff, highest_in;
   logic [WIN_SIZE-1:0]          bitmap_ff, bitmap_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   drf_pkg::qentry_type          rsp_ff;
   drf_pkg::qentry_type          rsp_entry;
   drf_pkg::status_type          status;

   logic                         out_free;
   logic                         is_clear;
   logic                         pop_dgram;
   logic [drf_pkg::NUM_W-1:0]    num;
   logic                         newer;
   logic [drf_pkg::NUM_W-1:0]    fwd;
   logic [drf_pkg::NUM_W-1:0]    bwd;
   logic                         fwd_in_win;
   logic                         bwd_in_win;
   logic [WIN_SIZE-1:0]          shifted;
   logic                         hit;

   // config register
   assign replay_en_in = csr_wr_en ? csr_wr_data : replay_en_ff;

   // pop: clears always drain, datagrams need room in the result register
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign is_clear  = (head.kind == drf_pkg::REQ_CLEAR);
   assign pop       = head_valid && (is_clear || out_free);
   assign pop_dgram = pop && !is_clear;

   // window distance terms
   assign num        = {head.epoch, head.seq};
   assign newer      = num > highest_ff;
   assign fwd        = num - highest_ff;
   assign bwd        = highest_ff - num;
   assign fwd_in_win = fwd < WIN_LIMIT;
   assign bwd_in_win = bwd < WIN_LIMIT;
   assign shifted    = fwd_in_win ? (bitmap_ff << fwd[SHW-1:0]) : '0;
   assign hit        = bitmap_ff[bwd[SHW-1:0]];

   // status and window update
   always_comb begin
      status     = head.status;
      highest_in = highest_ff;
      bitmap_in  = bitmap_ff;
      if (pop && is_clear) begin
         highest_in = '0;
         bitmap_in  = '0;
      end else if (pop_dgram && head.status == drf_pkg::ST_ACCEPT && replay_en_ff) begin
         priority if (newer) begin
            highest_in = num;
            bitmap_in  = shifted | BIT_ZERO;
         end else if (!bwd_in_win) begin
            status = drf_pkg::ST_TOO_OLD;
         end else if (hit) begin
            status = drf_pkg::ST_DUPLICATE;
         end else begin
            bitmap_in = bitmap_ff | (BIT_ZERO << bwd[SHW-1:0]);
         end
      end
   end

   // result register handshake
   always_comb begin
      priority if (pop_dgram) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         replay_en_ff <= 1'b0;
         highest_ff   <= '0;
         bitmap_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         replay_en_ff <= replay_en_in;
         highest_ff   <= highest_in;
         bitmap_ff    <= bitmap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload with the final status
   always_comb begin
      rsp_entry        = head;
      rsp_entry.status = status;
   end

   always_ff @(posedge clock) begin
      if (pop_dgram) begin
         rsp_ff <= rsp_entry;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_ff.status;
   assign rsp_record_type     = rsp_ff.rec_type;
   assign rsp_epoch_out       = rsp_ff.epoch;
   assign rsp_seq_out         = rsp_ff.seq;
   assign rsp_record_length   = rsp_ff.rec_len;
   assign rsp_datagram_length = rsp_ff.dgram_len;

endmodule
